// File: rtl/hisc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hisc_pkg
// Shared types and constants for the homography inlier scoring core.
// ----------------------------------------------------------------------------
package hisc_pkg;

   localparam int MAX_MATCHES = 4096;
   localparam int CNT_CAP_INT = (MAX_MATCHES < 8191) ? MAX_MATCHES : 8191;
   localparam logic [12:0] CNT_CAP = 13'(CNT_CAP_INT);

   // 5.991 in Q.16
   localparam logic signed [25:0] CHI_SQ_Q16 = 26'sd392626;
   localparam logic [47:0] SAT48 = {48{1'b1}};
   localparam logic [55:0] DIFF_CLAMP = 56'd16777216;

   // register indexes on the csr port
   localparam logic [2:0] CSR_FWD_ROW0 = 3'd0;
   localparam logic [2:0] CSR_FWD_ROW1 = 3'd1;
   localparam logic [2:0] CSR_FWD_ROW2 = 3'd2;
   localparam logic [2:0] CSR_INV_ROW0 = 3'd3;
   localparam logic [2:0] CSR_INV_ROW1 = 3'd4;
   localparam logic [2:0] CSR_INV_ROW2 = 3'd5;
   localparam logic [2:0] CSR_SIGMA    = 3'd6;

   localparam logic [15:0] SIGMA_RESET = 16'd256;

   typedef struct packed {
      logic signed [23:0] first_x;
      logic signed [23:0] first_y;
      logic signed [23:0] second_x;
      logic signed [23:0] second_y;
      logic               final_pair;
   } item_type;

   typedef struct packed {
      logic [2:0][62:0] fwd;
      logic [2:0][62:0] inv;
      logic [15:0]      sigma;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/hisc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hisc_front
// Two-entry item queue between the request port and the compute sequencer.
// ----------------------------------------------------------------------------
module hisc_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   output logic                     full,
   input  wire hisc_pkg::item_type  push_item,
   output logic                     q_empty,
   input  wire                      q_pop,
   output hisc_pkg::item_type       q_item
);

   hisc_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push;
   logic       do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && !q_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/hisc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hisc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hisc_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [53:0] dividend,
   input  wire  [45:0] divisor,
   output logic        done,
   output logic [53:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [45:0] rem_ff;
   logic [53:0] quo_ff;
   logic [45:0] dvs_ff;
   logic [46:0] trial;
   logic        fits;
   logic [46:0] diff;

   assign trial = {rem_ff, quo_ff[53]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd53;
            rem_ff  <= 46'd0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[45:0] : trial[45:0];
            quo_ff <= {quo_ff[52:0], fits};
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/hisc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hisc_back
// Compute sequencer: shared multiply-accumulate, divider, cost and result beat.
// ----------------------------------------------------------------------------
module hisc_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire hisc_pkg::cfg_type   cfg,
   input  wire                      q_empty,
   output logic                     q_pop,
   input  wire hisc_pkg::item_type  q_item,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output logic                     rsp_inlier,
   output logic [12:0]              rsp_inlier_count,
   output logic [47:0]              rsp_total_cost,
   output logic                     rsp_set_done
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_THR1, ST_THR2, ST_DOT, ST_DIVS, ST_DIVW, ST_SQ, ST_DONE
   } state_type;

   state_type          state_ff;
   hisc_pkg::item_type item_ff;
   logic [3:0]         step_ff;
   logic [31:0]        sig2_ff;
   logic [35:0]        thr_ff;
   logic signed [45:0] acc_ff;
   logic signed [45:0] num_ff [6];
   logic [24:0]        d_ff [4];
   logic [49:0]        sq_ff;
   logic [47:0]        dist_ff [2];
   logic               div_start_ff;
   logic [12:0]        count_ff;
   logic [47:0]        cost_ff;
   logic               rsp_valid_ff;
   logic               inl_ff;
   logic [12:0]        out_count_ff;
   logic [47:0]        out_cost_ff;
   logic               last_ff;

   logic signed [32:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [58:0] prod;
   logic [2:0]         rr;
   logic [1:0]         rsel;
   logic [62:0]        row;
   logic signed [20:0] c0, c1, c2;
   logic signed [23:0] px, py;
   logic signed [45:0] dot_sum;

   logic signed [45:0] dnum, dden;
   logic [45:0]        num_mag, den_mag;
   logic               div_done;
   logic [53:0]        div_q;
   logic signed [54:0] qs;
   logic signed [23:0] pt;
   logic signed [55:0] diff;
   logic [55:0]        mag;
   logic [24:0]        dclamp;
   logic [49:0]        sq_sum;
   logic [47:0]        sq_sat;

   logic               zero_any;
   logic [47:0]        worst_dist;
   logic [47:0]        thr48;
   logic               inl;
   logic [47:0]        add;
   logic [48:0]        cost_sum;
   logic [47:0]        cost_new;
   logic [12:0]        count_new;
   logic               rsp_load;

   // dot-product row and point select
   assign rr   = step_ff[3:1];
   assign rsel = (rr < 3'd3) ? rr[1:0] : 2'(rr - 3'd3);
   assign row  = (rr < 3'd3) ? cfg.fwd[rsel] : cfg.inv[rsel];
   assign c0   = row[20:0];
   assign c1   = row[41:21];
   assign c2   = row[62:42];
   assign px   = (rr < 3'd3) ? item_ff.first_x : item_ff.second_x;
   assign py   = (rr < 3'd3) ? item_ff.first_y : item_ff.second_y;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_THR1: begin
            mul_a = 33'({17'd0, cfg.sigma});
            mul_b = 26'({10'd0, cfg.sigma});
         end
         ST_THR2: begin
            mul_a = 33'({1'b0, sig2_ff});
            mul_b = hisc_pkg::CHI_SQ_Q16;
         end
         ST_DOT: begin
            mul_a = step_ff[0] ? 33'(c1) : 33'(c0);
            mul_b = step_ff[0] ? 26'(py) : 26'(px);
         end
         ST_SQ: begin
            mul_a = 33'({8'd0, d_ff[step_ff[1:0]]});
            mul_b = 26'({1'b0, d_ff[step_ff[1:0]]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign dot_sum = acc_ff + prod[45:0] + {{17{c2[20]}}, c2, 8'd0};

   // divider operands
   always_comb begin
      case (step_ff[1:0])
         2'd0:    dnum = num_ff[0];
         2'd1:    dnum = num_ff[1];
         2'd2:    dnum = num_ff[3];
         default: dnum = num_ff[4];
      endcase
      dden = step_ff[1] ? num_ff[5] : num_ff[2];
      case (step_ff[1:0])
         2'd0:    pt = item_ff.second_x;
         2'd1:    pt = item_ff.second_y;
         2'd2:    pt = item_ff.first_x;
         default: pt = item_ff.first_y;
      endcase
   end

   assign num_mag = dnum[45] ? 46'(-dnum) : 46'(dnum);
   assign den_mag = dden[45] ? 46'(-dden) : 46'(dden);

   hisc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend ({num_mag, 8'd0}),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // signed quotient, truncated toward zero, then clamped |partner - mapped|
   assign qs     = (dnum[45] ^ dden[45]) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign diff   = 56'(pt) - 56'(qs);
   assign mag    = diff[55] ? 56'(-diff) : 56'(diff);
   assign dclamp = (mag > hisc_pkg::DIFF_CLAMP) ? 25'(hisc_pkg::DIFF_CLAMP) : mag[24:0];

   assign sq_sum = sq_ff + prod[49:0];
   assign sq_sat = (sq_sum > {2'b00, hisc_pkg::SAT48}) ? hisc_pkg::SAT48 : sq_sum[47:0];

   // scoring
   assign zero_any   = (num_ff[2] == '0) || (num_ff[5] == '0);
   assign worst_dist = (dist_ff[0] > dist_ff[1]) ? dist_ff[0] : dist_ff[1];
   assign thr48      = {12'd0, thr_ff};
   assign inl        = !zero_any && (thr48 > worst_dist);
   assign add        = inl ? worst_dist : thr48;
   assign cost_sum   = {1'b0, cost_ff} + {1'b0, add};
   assign cost_new   = cost_sum[48] ? hisc_pkg::SAT48 : cost_sum[47:0];
   assign count_new  = (inl && (count_ff < hisc_pkg::CNT_CAP)) ? count_ff + 13'd1 : count_ff;

   // result register loads when free or emptied in the same cycle
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_pop);

   assign q_pop            = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_inlier       = inl_ff;
   assign rsp_inlier_count = out_count_ff;
   assign rsp_total_cost   = out_cost_ff;
   assign rsp_set_done     = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 4'd0;
         div_start_ff <= 1'b0;
         count_ff     <= 13'd0;
         cost_ff      <= 48'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  item_ff  <= q_item;
                  state_ff <= ST_THR1;
               end
            end
            ST_THR1: begin
               sig2_ff  <= prod[31:0];
               state_ff <= ST_THR2;
            end
            ST_THR2: begin
               thr_ff   <= 36'((prod[50:0] + 51'd32768) >> 16);
               step_ff  <= 4'd0;
               state_ff <= ST_DOT;
            end
            ST_DOT: begin
               if (!step_ff[0]) begin
                  acc_ff <= prod[45:0];
               end else begin
                  num_ff[rr] <= dot_sum;
               end
               if (step_ff == 4'd11) begin
                  step_ff  <= 4'd0;
                  state_ff <= ST_DIVS;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_DIVS: begin
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_done) begin
                  d_ff[step_ff[1:0]] <= dclamp;
                  if (step_ff == 4'd3) begin
                     step_ff  <= 4'd0;
                     state_ff <= ST_SQ;
                  end else begin
                     step_ff  <= step_ff + 4'd1;
                     state_ff <= ST_DIVS;
                  end
               end
            end
            ST_SQ: begin
               if (!step_ff[0]) begin
                  sq_ff <= prod[49:0];
               end else begin
                  dist_ff[step_ff[1]] <= sq_sat;
               end
               if (step_ff == 4'd3) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  inl_ff       <= inl;
                  out_count_ff <= count_new;
                  out_cost_ff  <= cost_new;
                  last_ff      <= item_ff.final_pair;
                  if (item_ff.final_pair) begin
                     count_ff <= 13'd0;
                     cost_ff  <= 48'd0;
                  end else begin
                     count_ff <= count_new;
                     cost_ff  <= cost_new;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/homography_inlier_scoring_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// homography_inlier_scoring_core
// Symmetric transfer error inlier test with running inlier count and cost.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 beat
//  req_     in         push / full               one point pair
//  rsp_     out        pop / empty               inlier flag and running totals
//  csr_     in         csr_valid / csr_ready     register index and data
//
//  with the result register free, one item passes through fetch, the
//  threshold, six dot products, four divides (each a start, the quotient
//  steps and a handoff), four squares and the post to the result register
//  a two-entry queue takes new beats while the sequencer works
//  synchronous active-high reset clears totals, zero matrices, sigma 1 px
//  the sequencer holds only while the result register is still full
// ----------------------------------------------------------------------------
module homography_inlier_scoring_core (
   input  wire         clock,
   input  wire         reset,
   // request queue side
   input  wire         push,
   output logic        full,
   input  wire  [23:0] req_first_x,
   input  wire  [23:0] req_first_y,
   input  wire  [23:0] req_second_x,
   input  wire  [23:0] req_second_y,
   input  wire         req_final_pair,
   // result queue side
   output logic        empty,
   input  wire         pop,
   output logic        rsp_inlier,
   output logic [12:0] rsp_inlier_count,
   output logic [47:0] rsp_total_cost,
   output logic        rsp_set_done,
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [62:0] csr_data
);

   hisc_pkg::cfg_type  cfg_ff;
   hisc_pkg::item_type push_item;
   hisc_pkg::item_type q_item;
   logic               q_empty;
   logic               q_pop;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd   <= '0;
         cfg_ff.inv   <= '0;
         cfg_ff.sigma <= hisc_pkg::SIGMA_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            hisc_pkg::CSR_FWD_ROW0: cfg_ff.fwd[0] <= csr_data;
            hisc_pkg::CSR_FWD_ROW1: cfg_ff.fwd[1] <= csr_data;
            hisc_pkg::CSR_FWD_ROW2: cfg_ff.fwd[2] <= csr_data;
            hisc_pkg::CSR_INV_ROW0: cfg_ff.inv[0] <= csr_data;
            hisc_pkg::CSR_INV_ROW1: cfg_ff.inv[1] <= csr_data;
            hisc_pkg::CSR_INV_ROW2: cfg_ff.inv[2] <= csr_data;
            hisc_pkg::CSR_SIGMA:    cfg_ff.sigma  <= csr_data[15:0];
            default:                cfg_ff        <= cfg_ff;
         endcase
      end
   end

   assign push_item.first_x    = req_first_x;
   assign push_item.first_y    = req_first_y;
   assign push_item.second_x   = req_second_x;
   assign push_item.second_y   = req_second_y;
   assign push_item.final_pair = req_final_pair;

   // front: item queue
   hisc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_item (push_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   // back: projection, divide, distance, scoring and result register
   hisc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_inlier       (rsp_inlier),
      .rsp_inlier_count (rsp_inlier_count),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_set_done     (rsp_set_done)
   );

endmodule

`default_nettype wire
